[hdl/assert_macros.svh]
// Assertion macros shared by the alarm table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ATM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ATM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hdl/atm_pkg.sv]
// Shared types and constants of the alarm table manager.
package atm_pkg;
	localparam int TableSlotsDefault = 16;
	localparam int TypeCountDefault = 16;
	localparam logic [15:0] DebounceReset = 16'd1000;

	localparam logic [2:0] ModeRaise = 3'd0;
	localparam logic [2:0] ModeClearType = 3'd1;
	localparam logic [2:0] ModeClearAll = 3'd2;
	localparam logic [2:0] ModeAckSlot = 3'd3;
	localparam logic [2:0] ModeAckAll = 3'd4;
	localparam logic [2:0] ModeRead = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_APPLY,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic shift_load;
		logic shift_step;
		logic apply;
		logic read;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic shift_last;
		logic need_shift;
	} stat_t;

	function automatic logic [6:0] penalty(input logic [1:0] sev);
		case (sev)
			2'd0: penalty = 7'd1;
			2'd1: penalty = 7'd5;
			2'd2: penalty = 7'd10;
			default: penalty = 7'd25;
		endcase
	endfunction
endpackage

[hdl/alarm_table_manager_core.sv]
// Top level of the alarm table manager.
// Usage: write debounce_ms through cfg_valid/cfg_ready/cfg_data while idle;
// cfg_ready is high whenever busy is low (reset value 1000 ms).
// Raise start with the item fields while busy is low; the item is taken at
// that edge and busy rises. One result appears for exactly one cycle with
// done high; the receiver cannot stall it and must take it then.
// A result follows its item after the slot search pass and the health-score
// pass, both of which visit one slot per cycle, and after the states that pick
// the path, apply the update and finish; when a full table compacts, a
// one-slot-per-cycle shift comes before the update.
// Reset empties the table, clears counts, flags and debounce timers, and
// returns the block to idle with busy low.
// A raise refused by debounce or with a reserved type changes no state.
// Busy is already low while done is high, so the next item can be started
// in that same cycle.
module alarm_table_manager_core #(
	parameter int TABLE_SLOTS = atm_pkg::TableSlotsDefault,
	parameter int TYPE_COUNT = atm_pkg::TypeCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic [2:0]  mode,
	input  logic [31:0] now_ms,
	input  logic [3:0]  alarm_type,
	input  logic [1:0]  severity,
	input  logic [31:0] value_bits,
	input  logic [31:0] threshold_bits,
	input  logic [3:0]  slot,
	output logic        done,
	output logic        accepted,
	output logic [3:0]  slot_out,
	output logic [3:0]  entry_type,
	output logic [1:0]  entry_severity,
	output logic [31:0] entry_value_bits,
	output logic [31:0] entry_threshold_bits,
	output logic [15:0] entry_count,
	output logic        entry_active,
	output logic        entry_acked,
	output logic [31:0] entry_age_ms,
	output logic [4:0]  active_count,
	output logic [6:0]  health_level
);
	atm_pkg::cmd_t  cmd;
	atm_pkg::stat_t stat;
	logic [15:0] debounce_q;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= atm_pkg::DebounceReset;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	atm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	atm_dp #(.TABLE_SLOTS(TABLE_SLOTS), .TYPE_COUNT(TYPE_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .debounce_ms(debounce_q),
		.mode(mode), .now_ms(now_ms), .alarm_type(alarm_type), .severity(severity),
		.value_bits(value_bits), .threshold_bits(threshold_bits), .slot(slot),
		.done(done), .accepted(accepted), .slot_out(slot_out), .entry_type(entry_type),
		.entry_severity(entry_severity), .entry_value_bits(entry_value_bits),
		.entry_threshold_bits(entry_threshold_bits), .entry_count(entry_count),
		.entry_active(entry_active), .entry_acked(entry_acked),
		.entry_age_ms(entry_age_ms), .active_count(active_count),
		.health_level(health_level)
	);
endmodule

[hdl/atm_ctrl.sv]
// Sequencer of the alarm table manager.
`include "assert_macros.svh"
module atm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  atm_pkg::stat_t  stat,
	output atm_pkg::cmd_t   cmd,
	output logic            busy
);
	atm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			atm_pkg::ST_IDLE: begin
				if (start) state_d = atm_pkg::ST_SCAN;
			end
			atm_pkg::ST_SCAN: begin
				if (stat.scan_last) state_d = atm_pkg::ST_DECIDE;
			end
			atm_pkg::ST_DECIDE: begin
				state_d = stat.need_shift ? atm_pkg::ST_SHIFT : atm_pkg::ST_APPLY;
			end
			atm_pkg::ST_SHIFT: begin
				if (stat.shift_last) state_d = atm_pkg::ST_APPLY;
			end
			atm_pkg::ST_APPLY: state_d = atm_pkg::ST_READ;
			atm_pkg::ST_READ: begin
				if (stat.scan_last) state_d = atm_pkg::ST_DONE;
			end
			atm_pkg::ST_DONE: state_d = atm_pkg::ST_IDLE;
			default: state_d = atm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != atm_pkg::ST_IDLE);
		case (state_q)
			atm_pkg::ST_IDLE: begin
				cmd.load = start;
				cmd.scan_clr = start;
			end
			atm_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			atm_pkg::ST_DECIDE: cmd.shift_load = stat.need_shift;
			atm_pkg::ST_SHIFT: cmd.shift_step = 1'b1;
			atm_pkg::ST_APPLY: cmd.apply = 1'b1;
			atm_pkg::ST_READ: cmd.read = 1'b1;
			atm_pkg::ST_DONE: cmd.finish = 1'b1;
			default: cmd = '0;
		endcase
	end

	`ATM_ASSERT_IMP(a_busy_on_start, clk, arst_n, state_q == atm_pkg::ST_IDLE && start, cmd.load, "start not loaded")
	`ATM_ASSERT_NEXT(a_done_idle, clk, arst_n, cmd.finish, state_q == atm_pkg::ST_IDLE, "done not followed by idle")
	`ATM_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.scan_step, cmd.shift_load, cmd.shift_step, cmd.apply, cmd.read, cmd.finish}), "overlapping commands")
endmodule

[hdl/atm_dp.sv]
// Slot table, search, compaction and result logic of the alarm table manager.
`include "assert_macros.svh"
module atm_dp #(
	parameter int TABLE_SLOTS = atm_pkg::TableSlotsDefault,
	parameter int TYPE_COUNT = atm_pkg::TypeCountDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  atm_pkg::cmd_t   cmd,
	output atm_pkg::stat_t  stat,
	input  logic [15:0]     debounce_ms,
	input  logic [2:0]      mode,
	input  logic [31:0]     now_ms,
	input  logic [3:0]      alarm_type,
	input  logic [1:0]      severity,
	input  logic [31:0]     value_bits,
	input  logic [31:0]     threshold_bits,
	input  logic [3:0]      slot,
	output logic            done,
	output logic            accepted,
	output logic [3:0]      slot_out,
	output logic [3:0]      entry_type,
	output logic [1:0]      entry_severity,
	output logic [31:0]     entry_value_bits,
	output logic [31:0]     entry_threshold_bits,
	output logic [15:0]     entry_count,
	output logic            entry_active,
	output logic            entry_acked,
	output logic [31:0]     entry_age_ms,
	output logic [4:0]      active_count,
	output logic [6:0]      health_level
);
	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int TW = $clog2(TYPE_COUNT);
	localparam logic [SW-1:0] LastSlot = SW'(TABLE_SLOTS - 1);

	logic [3:0]  type_q [TABLE_SLOTS];
	logic [1:0]  sev_q [TABLE_SLOTS];
	logic [31:0] val_q [TABLE_SLOTS];
	logic [31:0] thr_q [TABLE_SLOTS];
	logic [15:0] cnt_q [TABLE_SLOTS];
	logic        act_q [TABLE_SLOTS];
	logic        ack_q [TABLE_SLOTS];
	logic [31:0] since_q [TABLE_SLOTS];
	logic [31:0] last_q [TYPE_COUNT];
	logic [CW-1:0] used_q, act_tot_q;

	logic [2:0]  mode_q;
	logic [31:0] now_q, val_in_q, thr_in_q;
	logic [3:0]  type_in_q, slot_in_q;
	logic [1:0]  sev_in_q;

	logic [SW-1:0] idx_q;
	logic          found_q, empty_ok_q, inact_ok_q;
	logic [SW-1:0] found_idx_q, empty_idx_q, inact_idx_q;
	logic [6:0]    score_q;
	logic          acc_q, show_q;
	logic [SW-1:0] show_idx_q;

	logic type_ok, in_used, deb_ok;
	logic [SW-1:0] sel_idx;

	assign type_ok = (type_in_q != 4'd0) && ({28'd0, type_in_q} < 32'(TYPE_COUNT));
	assign in_used = ({{(32 - CW){1'b0}}, used_q} > {{(32 - SW){1'b0}}, idx_q});
	assign deb_ok = ((now_q - last_q[TW'(type_in_q)]) >= {16'd0, debounce_ms});
	assign stat.scan_last = (idx_q == LastSlot);
	assign stat.shift_last = (idx_q == LastSlot - SW'(1));
	assign stat.need_shift = (mode_q == atm_pkg::ModeRaise) && type_ok && deb_ok &&
		!found_q && !empty_ok_q && inact_ok_q && (inact_idx_q != LastSlot);
	assign sel_idx = found_q ? found_idx_q : (empty_ok_q ? empty_idx_q : LastSlot);

	logic slot_ok;
	assign slot_ok = ({28'd0, slot_in_q} < 32'(TABLE_SLOTS)) &&
		({{(32 - CW){1'b0}}, used_q} > {28'd0, slot_in_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			now_q <= now_ms;
			type_in_q <= alarm_type;
			sev_in_q <= severity;
			val_in_q <= value_bits;
			thr_in_q <= threshold_bits;
			slot_in_q <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			empty_ok_q <= 1'b0;
			inact_ok_q <= 1'b0;
			found_idx_q <= '0;
			empty_idx_q <= '0;
			inact_idx_q <= '0;
			score_q <= 7'd100;
			acc_q <= 1'b0;
			show_q <= 1'b0;
			show_idx_q <= '0;
			used_q <= '0;
			act_tot_q <= '0;
			done <= 1'b0;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				type_q[i] <= 4'd0;
				cnt_q[i] <= 16'd0;
				act_q[i] <= 1'b0;
				ack_q[i] <= 1'b0;
			end
			for (int t = 0; t < TYPE_COUNT; t++) last_q[t] <= 32'd0;
		end else begin
			done <= cmd.finish;
			if (cmd.scan_clr) begin
				idx_q <= '0;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
				empty_ok_q <= 1'b0;
				inact_ok_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + SW'(1);
				if (!found_q && in_used && type_q[idx_q] == type_in_q) begin
					found_q <= 1'b1;
					found_idx_q <= idx_q;
				end
				if (!empty_ok_q && type_q[idx_q] == 4'd0) begin
					empty_ok_q <= 1'b1;
					empty_idx_q <= idx_q;
				end
				if (!inact_ok_q && !act_q[idx_q] && idx_q != LastSlot) begin
					inact_ok_q <= 1'b1;
					inact_idx_q <= idx_q;
				end
			end
			if (cmd.shift_load) begin
				idx_q <= inact_idx_q;
			end
			if (cmd.shift_step) begin
				idx_q <= idx_q + SW'(1);
				type_q[idx_q] <= type_q[idx_q + SW'(1)];
				sev_q[idx_q] <= sev_q[idx_q + SW'(1)];
				val_q[idx_q] <= val_q[idx_q + SW'(1)];
				thr_q[idx_q] <= thr_q[idx_q + SW'(1)];
				cnt_q[idx_q] <= cnt_q[idx_q + SW'(1)];
				act_q[idx_q] <= act_q[idx_q + SW'(1)];
				ack_q[idx_q] <= ack_q[idx_q + SW'(1)];
				since_q[idx_q] <= since_q[idx_q + SW'(1)];
				if (stat.shift_last) begin
					type_q[LastSlot] <= 4'd0;
					act_q[LastSlot] <= 1'b0;
					used_q <= used_q - CW'(1);
				end
			end
			if (cmd.apply) begin
				idx_q <= '0;
				score_q <= 7'd100;
				acc_q <= 1'b0;
				show_q <= 1'b0;
				show_idx_q <= '0;
				case (mode_q)
					atm_pkg::ModeRaise: begin
						if (type_ok && deb_ok) begin
							acc_q <= 1'b1;
							show_q <= 1'b1;
							show_idx_q <= sel_idx;
							last_q[TW'(type_in_q)] <= now_q;
							sev_q[sel_idx] <= sev_in_q;
							val_q[sel_idx] <= val_in_q;
							thr_q[sel_idx] <= thr_in_q;
							if (found_q) begin
								if (cnt_q[sel_idx] != 16'hFFFF)
									cnt_q[sel_idx] <= cnt_q[sel_idx] + 16'd1;
								if (!act_q[sel_idx]) begin
									act_q[sel_idx] <= 1'b1;
									since_q[sel_idx] <= now_q;
									ack_q[sel_idx] <= 1'b0;
									act_tot_q <= act_tot_q + CW'(1);
								end
							end else begin
								type_q[sel_idx] <= type_in_q;
								since_q[sel_idx] <= now_q;
								act_q[sel_idx] <= 1'b1;
								ack_q[sel_idx] <= 1'b0;
								cnt_q[sel_idx] <= 16'd1;
								if ({{(32 - CW){1'b0}}, used_q} <= {{(32 - SW){1'b0}}, sel_idx})
									used_q <= CW'({1'b0, sel_idx} + (SW + 1)'(1));
								if (!(({{(32 - CW){1'b0}}, used_q} >
									{{(32 - SW){1'b0}}, sel_idx}) && act_q[sel_idx]))
									act_tot_q <= act_tot_q + CW'(1);
							end
						end
					end
					atm_pkg::ModeClearType: begin
						if (type_in_q != 4'd0 && found_q && act_q[found_idx_q]) begin
							act_q[found_idx_q] <= 1'b0;
							if (act_tot_q != '0) act_tot_q <= act_tot_q - CW'(1);
							acc_q <= 1'b1;
							show_q <= 1'b1;
							show_idx_q <= found_idx_q;
						end
					end
					atm_pkg::ModeClearAll: begin
						for (int i = 0; i < TABLE_SLOTS; i++)
							if ({{(32 - CW){1'b0}}, used_q} > 32'(i)) act_q[i] <= 1'b0;
						act_tot_q <= '0;
						acc_q <= 1'b1;
					end
					atm_pkg::ModeAckSlot: begin
						if (slot_ok) begin
							ack_q[SW'(slot_in_q)] <= 1'b1;
							acc_q <= 1'b1;
							show_q <= 1'b1;
							show_idx_q <= SW'(slot_in_q);
						end
					end
					atm_pkg::ModeAckAll: begin
						for (int i = 0; i < TABLE_SLOTS; i++)
							if ({{(32 - CW){1'b0}}, used_q} > 32'(i)) ack_q[i] <= 1'b1;
						acc_q <= 1'b1;
					end
					atm_pkg::ModeRead: begin
						if (slot_ok) begin
							acc_q <= 1'b1;
							show_q <= 1'b1;
							show_idx_q <= SW'(slot_in_q);
						end
					end
					default: acc_q <= 1'b0;
				endcase
			end
			if (cmd.read) begin
				idx_q <= idx_q + SW'(1);
				if (in_used && act_q[idx_q]) begin
					score_q <= (score_q > atm_pkg::penalty(sev_q[idx_q])) ?
						score_q - atm_pkg::penalty(sev_q[idx_q]) : 7'd0;
				end
			end
		end
	end

	always_comb begin
		accepted = acc_q;
		slot_out = '0;
		if (mode_q == atm_pkg::ModeAckSlot || mode_q == atm_pkg::ModeRead) slot_out = slot_in_q;
		else if (acc_q && (mode_q == atm_pkg::ModeRaise || mode_q == atm_pkg::ModeClearType))
			slot_out = 4'({{(32 - SW){1'b0}}, show_idx_q});
		entry_type = show_q ? type_q[show_idx_q] : 4'd0;
		entry_severity = show_q ? sev_q[show_idx_q] : 2'd0;
		entry_value_bits = show_q ? val_q[show_idx_q] : 32'd0;
		entry_threshold_bits = show_q ? thr_q[show_idx_q] : 32'd0;
		entry_count = show_q ? cnt_q[show_idx_q] : 16'd0;
		entry_active = show_q && act_q[show_idx_q];
		entry_acked = show_q && ack_q[show_idx_q];
		entry_age_ms = (show_q && act_q[show_idx_q]) ? now_q - since_q[show_idx_q] : 32'd0;
		active_count = 5'({{(32 - CW){1'b0}}, act_tot_q});
		health_level = score_q;
	end

	`ATM_ASSERT_IMP(a_act_le_used, clk, arst_n, 1'b1, act_tot_q <= used_q, "active count above used slots")
	`ATM_ASSERT_IMP(a_score_range, clk, arst_n, 1'b1, score_q <= 7'd100, "health score out of range")
	`ATM_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done longer than one cycle")
endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the alarm table manager: directed and random items, with a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ModeSpare0 = 3'd6;
	localparam logic [2:0] ModeSpare1 = 3'd7;
	localparam int Slots = 16;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] now;
		logic [3:0]  kind;
		logic [1:0]  sev;
		logic [31:0] value;
		logic [31:0] thresh;
		logic [3:0]  slot;
	} item_t;

	typedef struct {
		logic        accepted;
		logic [3:0]  slot_out;
		logic [3:0]  kind;
		logic [1:0]  sev;
		logic [31:0] value;
		logic [31:0] thresh;
		logic [15:0] count;
		logic        active;
		logic        acked;
		logic [31:0] age;
		logic [4:0]  active_count;
		logic [6:0]  health;
	} alarm_result_t;

	typedef struct {
		logic [3:0]  kind;
		logic [1:0]  sev;
		logic [31:0] value;
		logic [31:0] thresh;
		logic [15:0] count;
		logic        active;
		logic        acked;
		logic [31:0] since;
	} alarm_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_valid = 1'b0;
	logic [15:0] cfg_data = '0;
	logic [2:0] mode = '0;
	logic [31:0] now_ms = '0;
	logic [3:0] alarm_type = '0;
	logic [1:0] severity = '0;
	logic [31:0] value_bits = '0;
	logic [31:0] threshold_bits = '0;
	logic [3:0] slot = '0;
	logic busy, cfg_ready, done, accepted, entry_active, entry_acked;
	logic [3:0] slot_out, entry_type;
	logic [1:0] entry_severity;
	logic [31:0] entry_value_bits, entry_threshold_bits, entry_age_ms;
	logic [15:0] entry_count;
	logic [4:0] active_count;
	logic [6:0] health_level;

	alarm_table_manager_core u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	alarm_slot_t   table_q[Slots];
	logic [31:0]   last_raise[16];
	int unsigned   used_cnt;
	int unsigned   active_cnt;
	logic [15:0]   debounce_ms;
	item_t         pending_items[$];
	alarm_result_t expected_results[$];
	int            mismatches = 0;
	int            idle_pct = 0;
	logic          took = 1'b0;
	logic [31:0]   clock_ms = 32'd2000;

	function automatic int raise_alarm(item_t it);
		int idx;
		logic was_active;
		if (it.kind == 4'd0) return -1;
		if (32'(it.now - last_raise[it.kind]) < {16'd0, debounce_ms}) return -1;
		last_raise[it.kind] = it.now;
		idx = -1;
		for (int i = 0; i < used_cnt; i++)
			if (idx < 0 && table_q[i].kind == it.kind) idx = i;
		if (idx >= 0) begin
			table_q[idx].sev = it.sev;
			table_q[idx].value = it.value;
			table_q[idx].thresh = it.thresh;
			if (table_q[idx].count != 16'hFFFF) table_q[idx].count++;
			if (!table_q[idx].active) begin
				table_q[idx].active = 1'b1;
				table_q[idx].since = it.now;
				table_q[idx].acked = 1'b0;
				active_cnt++;
			end
			return idx;
		end
		for (int i = 0; i < Slots; i++)
			if (idx < 0 && table_q[i].kind == 4'd0) idx = i;
		if (idx < 0) begin
			for (int i = 0; i < Slots - 1; i++) begin
				if (idx < 0 && !table_q[i].active) begin
					for (int j = i; j < Slots - 1; j++) table_q[j] = table_q[j + 1];
					table_q[Slots - 1].kind = 4'd0;
					table_q[Slots - 1].active = 1'b0;
					if (used_cnt > 0) used_cnt--;
					idx = 0;
				end
			end
			idx = Slots - 1;
		end
		was_active = (idx < used_cnt) && table_q[idx].active;
		table_q[idx].kind = it.kind;
		table_q[idx].sev = it.sev;
		table_q[idx].since = it.now;
		table_q[idx].value = it.value;
		table_q[idx].thresh = it.thresh;
		table_q[idx].active = 1'b1;
		table_q[idx].acked = 1'b0;
		table_q[idx].count = 16'd1;
		if (idx >= used_cnt) used_cnt = idx + 1;
		if (!was_active) active_cnt++;
		return idx;
	endfunction

	function automatic alarm_result_t predict_alarm(item_t it);
		alarm_result_t r;
		int shown;
		int score;
		r = '{default: '0};
		shown = -1;
		case (it.mode)
			atm_pkg::ModeRaise: begin
				shown = raise_alarm(it);
				if (shown >= 0) begin
					r.accepted = 1'b1;
					r.slot_out = 4'(shown);
				end
			end
			atm_pkg::ModeClearType: begin
				for (int i = 0; i < used_cnt; i++)
					if (shown < 0 && it.kind != 4'd0 && table_q[i].kind == it.kind) shown = i;
				if (shown >= 0 && table_q[shown].active) begin
					table_q[shown].active = 1'b0;
					if (active_cnt > 0) active_cnt--;
					r.accepted = 1'b1;
					r.slot_out = 4'(shown);
				end else begin
					shown = -1;
				end
			end
			atm_pkg::ModeClearAll: begin
				for (int i = 0; i < used_cnt; i++) table_q[i].active = 1'b0;
				active_cnt = 0;
				r.accepted = 1'b1;
			end
			atm_pkg::ModeAckSlot: begin
				r.slot_out = it.slot;
				if (it.slot < used_cnt) begin
					table_q[it.slot].acked = 1'b1;
					r.accepted = 1'b1;
					shown = it.slot;
				end
			end
			atm_pkg::ModeAckAll: begin
				for (int i = 0; i < used_cnt; i++) table_q[i].acked = 1'b1;
				r.accepted = 1'b1;
			end
			atm_pkg::ModeRead: begin
				r.slot_out = it.slot;
				if (it.slot < used_cnt) begin
					r.accepted = 1'b1;
					shown = it.slot;
				end
			end
			default: ;
		endcase
		if (shown >= 0) begin
			r.kind = table_q[shown].kind;
			r.sev = table_q[shown].sev;
			r.value = table_q[shown].value;
			r.thresh = table_q[shown].thresh;
			r.count = table_q[shown].count;
			r.active = table_q[shown].active;
			r.acked = table_q[shown].acked;
			r.age = table_q[shown].active ? it.now - table_q[shown].since : 32'd0;
		end
		score = 100;
		for (int i = 0; i < used_cnt; i++)
			if (table_q[i].active)
				case (table_q[i].sev)
					2'd0: score -= 1;
					2'd1: score -= 5;
					2'd2: score -= 10;
					default: score -= 25;
				endcase
		r.active_count = 5'(active_cnt);
		r.health = (score < 0) ? 7'd0 : 7'(score);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		alarm_result_t e;
		item_t it;
		took <= start && !busy;
		if (arst_n && cfg_valid && cfg_ready) debounce_ms = cfg_data;
		if (arst_n && start && !busy) begin
			it = '{mode, now_ms, alarm_type, severity, value_bits, threshold_bits, slot};
			expected_results.push_back(predict_alarm(it));
		end
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 32'd1, 32'd0);
			end else begin
				e = expected_results.pop_front();
				if (accepted !== e.accepted) report_mismatch("accepted", accepted, e.accepted);
				if (slot_out !== e.slot_out) report_mismatch("slot_out", slot_out, e.slot_out);
				if (entry_type !== e.kind) report_mismatch("entry_type", entry_type, e.kind);
				if (entry_severity !== e.sev)
					report_mismatch("entry_severity", entry_severity, e.sev);
				if (entry_value_bits !== e.value)
					report_mismatch("entry_value_bits", entry_value_bits, e.value);
				if (entry_threshold_bits !== e.thresh)
					report_mismatch("entry_threshold_bits", entry_threshold_bits, e.thresh);
				if (entry_count !== e.count) report_mismatch("entry_count", entry_count, e.count);
				if (entry_active !== e.active)
					report_mismatch("entry_active", entry_active, e.active);
				if (entry_acked !== e.acked) report_mismatch("entry_acked", entry_acked, e.acked);
				if (entry_age_ms !== e.age) report_mismatch("entry_age_ms", entry_age_ms, e.age);
				if (active_count !== e.active_count)
					report_mismatch("active_count", active_count, e.active_count);
				if (health_level !== e.health)
					report_mismatch("health_level", health_level, e.health);
			end
		end
	end

	always @(negedge clk) begin
		item_t it;
		if (arst_n && (!start || took)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				it = pending_items.pop_front();
				mode <= it.mode;
				now_ms <= it.now;
				alarm_type <= it.kind;
				severity <= it.sev;
				value_bits <= it.value;
				threshold_bits <= it.thresh;
				slot <= it.slot;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic add_item(logic [2:0] m, logic [31:0] t, logic [3:0] k, logic [1:0] s,
			logic [31:0] v, logic [31:0] th, logic [3:0] sl);
		pending_items.push_back('{m, t, k, s, v, th, sl});
	endtask

	task automatic add_random_item();
		int pick;
		logic [2:0] m;
		pick = $urandom_range(99);
		if (pick < 42) m = atm_pkg::ModeRaise;
		else if (pick < 56) m = atm_pkg::ModeClearType;
		else if (pick < 59) m = atm_pkg::ModeClearAll;
		else if (pick < 69) m = atm_pkg::ModeAckSlot;
		else if (pick < 72) m = atm_pkg::ModeAckAll;
		else if (pick < 96) m = atm_pkg::ModeRead;
		else m = pick[0] ? ModeSpare0 : ModeSpare1;
		if ($urandom_range(99) < 3) clock_ms = $urandom;
		else clock_ms += $urandom_range(0, 3000);
		add_item(m, clock_ms, ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
			2'($urandom), $urandom, $urandom, 4'($urandom));
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_debounce(logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#2000us;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < Slots; i++) table_q[i] = '{default: '0};
		for (int i = 0; i < 16; i++) last_raise[i] = '0;
		used_cnt = 0;
		active_cnt = 0;
		debounce_ms = atm_pkg::DebounceReset;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed items with the debounce at its reset value.
		add_item(atm_pkg::ModeRaise, 32'd10, 4'd3, 2'd3, 32'd1, 32'd2, 4'd0);
		add_item(atm_pkg::ModeRead, 32'd20, 4'd0, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'd5000, 4'd0, 2'd1, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'd5000, 4'd3, 2'd3, 32'hFFFF_FFFF, 32'd0, 4'd15);
		add_item(atm_pkg::ModeRaise, 32'd5500, 4'd3, 2'd1, 32'd7, 32'd7, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'd6000, 4'd15, 2'd0, 32'd0, 32'hFFFF_FFFF, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'd7000, 4'd3, 2'd2, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'd7000, 4'd7, 2'd1, 32'h1234_5678, 32'h8765_4321, 4'd0);
		add_item(atm_pkg::ModeRead, 32'd8000, 4'd0, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeAckSlot, 32'd8100, 4'd0, 2'd0, 32'd0, 32'd0, 4'd1);
		add_item(atm_pkg::ModeAckSlot, 32'd8200, 4'd0, 2'd0, 32'd0, 32'd0, 4'd15);
		add_item(atm_pkg::ModeClearType, 32'd8300, 4'd7, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeClearType, 32'd8400, 4'd7, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeClearType, 32'd8500, 4'd9, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeClearType, 32'd8600, 4'd0, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'd9000, 4'd7, 2'd3, 32'd3, 32'd4, 4'd0);
		add_item(atm_pkg::ModeAckAll, 32'd9100, 4'd0, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeRead, 32'd9200, 4'd0, 2'd0, 32'd0, 32'd0, 4'd2);
		add_item(atm_pkg::ModeClearAll, 32'd9300, 4'd0, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(atm_pkg::ModeRead, 32'd9400, 4'd0, 2'd0, 32'd0, 32'd0, 4'd0);
		add_item(ModeSpare0, 32'd9500, 4'd3, 2'd3, 32'd1, 32'd1, 4'd0);
		add_item(ModeSpare1, 32'd9600, 4'd3, 2'd3, 32'd1, 32'd1, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'hFFFF_FF00, 4'd5, 2'd2, 32'd9, 32'd9, 4'd0);
		add_item(atm_pkg::ModeRaise, 32'h0000_0100, 4'd5, 2'd2, 32'd9, 32'd9, 4'd0);
		add_item(atm_pkg::ModeRead, 32'h0000_0200, 4'd0, 2'd0, 32'd0, 32'd0, 4'd3);
		wait_idle();

		write_debounce(16'd0);
		idle_pct = 34;
		repeat (400) add_random_item();
		wait_idle();

		write_debounce(16'hFFFF);
		idle_pct = 66;
		repeat (300) add_random_item();
		wait_idle();

		write_debounce(16'($urandom_range(1, 2500)));
		idle_pct = 0;
		repeat (400) add_random_item();
		wait_idle();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
